// ----- sv/relative_target_pose_macros.svh -----
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef RELATIVE_TARGET_POSE_MACROS_SVH
`define RELATIVE_TARGET_POSE_MACROS_SVH

// same-cycle implication
`define RTP_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("relative_target_pose check failed");

// next-cycle implication
`define RTP_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("relative_target_pose check failed");

`endif

// ----- sv/rtp_pkg.sv -----
package rtp_pkg;

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] vehicle_x;
		logic signed [31:0] vehicle_y;
		logic signed [31:0] vehicle_z;
		logic signed [15:0] quat_i;
		logic signed [15:0] quat_j;
		logic signed [15:0] quat_k;
		logic signed [15:0] quat_real;
	} pose_t;

	typedef struct packed {
		logic signed [31:0] rel_forward;
		logic signed [31:0] rel_left;
		logic signed [31:0] rel_up;
		logic signed [15:0] bearing;
	} rel_t;

	// angle width (Q.28 radians), atan2 operand width, vectoring datapath width
	localparam int AngW = 32;
	localparam int ArgW = 36;
	localparam int VecW = 45;

	localparam logic signed [AngW-1:0] PI28      = 32'sd843314857;
	localparam logic signed [AngW-1:0] HALF_PI28 = 32'sd421657428;
	localparam logic signed [32:0]     INV_GAIN30 = 33'sd652032874;
	localparam logic signed [20:0]     PI13      = 21'sd25736;
	localparam logic signed [20:0]     TWO_PI13  = 21'sd51472;

	// yaw source
	localparam logic [1:0] YAW_DIRECT = 2'd0;
	localparam logic [1:0] YAW_NEG    = 2'd1;
	localparam logic [1:0] YAW_POS    = 2'd2;

	// atan(2^-i) in Q.28
	function automatic logic signed [AngW-1:0] atan_entry(input int i);
		logic signed [AngW-1:0] a;
		case (i)
			0: a = 32'sd210828714;
			1: a = 32'sd124459457;
			2: a = 32'sd65760959;
			3: a = 32'sd33381290;
			4: a = 32'sd16755422;
			5: a = 32'sd8385879;
			6: a = 32'sd4193963;
			7: a = 32'sd2097109;
			8: a = 32'sd1048571;
			9: a = 32'sd524287;
			10: a = 32'sd262144;
			11: a = 32'sd131072;
			12: a = 32'sd65536;
			13: a = 32'sd32768;
			14: a = 32'sd16384;
			15: a = 32'sd8192;
			16: a = 32'sd4096;
			17: a = 32'sd2048;
			18: a = 32'sd1024;
			19: a = 32'sd512;
			20: a = 32'sd256;
			21: a = 32'sd128;
			22: a = 32'sd64;
			23: a = 32'sd32;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ----- sv/rtp_atan2.sv -----
module rtp_atan2 import rtp_pkg::*; #(
	parameter int Iterations = 16
) (
	input  logic                   clk,
	input  logic [Iterations+3:0]  en,
	input  logic signed [ArgW-1:0] y,
	input  logic signed [ArgW-1:0] x,
	output logic signed [AngW-1:0] z
);

	typedef struct packed {
		logic signed [41:0] x;
		logic signed [41:0] y;
		logic        [40:0] m;
	} nrm_t;

	// scales x and y by 2^s when the top s bits of the magnitude are clear
	function automatic nrm_t nstep(input nrm_t a, input int s);
		nrm_t r;
		r = a;
		if ((a.m >> (41 - s)) == '0) begin
			r.x = a.x <<< s;
			r.y = a.y <<< s;
			r.m = a.m << s;
		end
		return r;
	endfunction

	nrm_t n0, nrm_s1, nrm_s2, nrm_s3;
	logic zero_s1, zero_s2, zero_s3;
	logic signed [41:0] xe, ye, ax, ay;

	logic signed [VecW-1:0] cx_sk [Iterations+1];
	logic signed [VecW-1:0] cy_sk [Iterations+1];
	logic signed [AngW-1:0] cz_sk [Iterations+1];
	logic [Iterations:0] zero_sk;

	always_comb begin
		xe = 42'(x);
		ye = 42'(y);
		ax = xe[41] ? -xe : xe;
		ay = ye[41] ? -ye : ye;
		n0.x = xe;
		n0.y = ye;
		n0.m = ax[40:0] | ay[40:0];
	end

	// normalize until the larger magnitude has bit 40 set
	always_ff @(posedge clk) begin
		if (en[0]) begin
			nrm_s1 <= nstep(nstep(n0, 32), 16);
			zero_s1 <= (n0.m == '0);
		end
		if (en[1]) begin
			nrm_s2 <= nstep(nstep(nrm_s1, 8), 4);
			zero_s2 <= zero_s1;
		end
		if (en[2]) begin
			nrm_s3 <= nstep(nstep(nrm_s2, 2), 1);
			zero_s3 <= zero_s2;
		end
	end

	// fold the left half plane
	always_ff @(posedge clk) begin
		if (en[3]) begin
			if (nrm_s3.x < 0) begin
				cz_sk[0] <= (nrm_s3.y >= 0) ? PI28 : -PI28;
				cx_sk[0] <= -VecW'(nrm_s3.x);
				cy_sk[0] <= -VecW'(nrm_s3.y);
			end else begin
				cz_sk[0] <= '0;
				cx_sk[0] <= VecW'(nrm_s3.x);
				cy_sk[0] <= VecW'(nrm_s3.y);
			end
			zero_sk[0] <= zero_s3;
		end
	end

	for (genvar i = 0; i < Iterations; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en[4+i]) begin
				if (cy_sk[i] > 0) begin
					cx_sk[i+1] <= cx_sk[i] + (cy_sk[i] >>> i);
					cy_sk[i+1] <= cy_sk[i] - (cx_sk[i] >>> i);
					cz_sk[i+1] <= cz_sk[i] + atan_entry(i);
				end else begin
					cx_sk[i+1] <= cx_sk[i] - (cy_sk[i] >>> i);
					cy_sk[i+1] <= cy_sk[i] + (cx_sk[i] >>> i);
					cz_sk[i+1] <= cz_sk[i] - atan_entry(i);
				end
				zero_sk[i+1] <= zero_sk[i];
			end
		end
	end

	assign z = zero_sk[Iterations] ? '0 : cz_sk[Iterations];

endmodule

// ----- sv/relative_target_pose.sv -----
// relative target pose: yaw from quaternion, offset rotated into the yaw frame, bearing
// throughput: one item per cycle while the output is not stalled; two vectoring cordic chains and one rotation chain,
// one stage per step, plus multiply stages
// a stalled result holds the last stage and the run of full stages behind it; bubbles upstream keep collapsing
// reset (arst_n low) clears all valid bits; data registers are not reset
`include "relative_target_pose_macros.svh"

module relative_target_pose import rtp_pkg::*; #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pose_valid,
	output logic  pose_stall,
	input  pose_t pose,
	output logic  rel_valid,
	input  logic  rel_stall,
	output rel_t  rel
);

	localparam int N = ANGLE_ITERATIONS;
	localparam int Stages = 2 * N + 13;
	localparam int KW1 = N + 7;
	localparam int KW2 = N + 8;
	localparam int KW3 = N + 9;
	localparam int KRot = N + 10;
	localparam int KF1 = 2 * N + 10;
	localparam int KM1 = 2 * N + 11;
	localparam int KM2 = 2 * N + 12;

	localparam logic signed [34:0] TwoPiW  = 35'sd1686629714;
	localparam logic signed [34:0] FourPiW = 35'sd3373259428;
	localparam logic signed [65:0] SatMax  = 66'sd2147483647;
	localparam logic signed [65:0] SatMin  = -66'sd2147483648;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [31:0] up;
	} side_t;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [31:0] up;
		logic signed [15:0] b;
		logic               flip;
	} rside_t;

	logic [Stages-1:0] v_q, adv;

	// stage k may load when it is empty or its content moves on
	always_comb begin
		adv[Stages-1] = !v_q[Stages-1] || !rel_stall;
		for (int k = Stages - 2; k >= 0; k--) begin
			adv[k] = !v_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= (adv & {v_q[Stages-2:0], pose_valid}) | (~adv & v_q);
		end
	end

	assign pose_stall = !adv[0];
	assign rel_valid = v_q[Stages-1];

	// stage 1: quaternion products and position differences
	logic signed [31:0] sx_s1, sy_s1, sz_s1, sw_s1, wy_s1, xz_s1, xy_s1, wz_s1;
	logic signed [15:0] qx_s1, qy_s1;
	side_t side_s1;
	logic signed [32:0] dz;

	always_comb begin
		dz = 33'(pose.target_z) - 33'(pose.vehicle_z);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			sx_s1 <= 32'(pose.quat_i) * 32'(pose.quat_i);
			sy_s1 <= 32'(pose.quat_j) * 32'(pose.quat_j);
			sz_s1 <= 32'(pose.quat_k) * 32'(pose.quat_k);
			sw_s1 <= 32'(pose.quat_real) * 32'(pose.quat_real);
			wy_s1 <= 32'(pose.quat_real) * 32'(pose.quat_j);
			xz_s1 <= 32'(pose.quat_i) * 32'(pose.quat_k);
			xy_s1 <= 32'(pose.quat_i) * 32'(pose.quat_j);
			wz_s1 <= 32'(pose.quat_real) * 32'(pose.quat_k);
			qx_s1 <= pose.quat_i;
			qy_s1 <= pose.quat_j;
			side_s1.mode <= YAW_DIRECT;
			side_s1.dx <= 33'(pose.target_x) - 33'(pose.vehicle_x);
			side_s1.dy <= 33'(pose.target_y) - 33'(pose.vehicle_y);
			if (dz[32] != dz[31]) begin
				side_s1.up <= dz[32] ? 32'sh80000000 : 32'sh7fffffff;
			end else begin
				side_s1.up <= dz[31:0];
			end
		end
	end

	// stage 2: gimbal test products and direct atan2 operands
	logic signed [33:0] norm, num;
	logic signed [51:0] numk_s2, normk_s2;
	logic signed [33:0] yy_s2, yx_s2;
	logic norm_pos_s2;
	logic signed [15:0] qx_s2, qy_s2;
	side_t side_s2;

	always_comb begin
		norm = 34'(sx_s1) + 34'(sy_s1) + 34'(sz_s1) + 34'(sw_s1);
		num = (34'(wy_s1) - 34'(xz_s1)) <<< 1;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			numk_s2 <= 52'(num) * 52'sd100000;
			normk_s2 <= 52'(norm) * 52'sd99999;
			norm_pos_s2 <= (norm != '0);
			yy_s2 <= (34'(xy_s1) + 34'(wz_s1)) <<< 1;
			yx_s2 <= 34'(sw_s1) + 34'(sx_s1) - 34'(sy_s1) - 34'(sz_s1);
			qx_s2 <= qx_s1;
			qy_s2 <= qy_s1;
			side_s2 <= side_s1;
		end
	end

	// stage 3: pick the yaw formula
	logic signed [ArgW-1:0] uy_s3, ux_s3;
	side_t side_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			side_s3.dx <= side_s2.dx;
			side_s3.dy <= side_s2.dy;
			side_s3.up <= side_s2.up;
			if (norm_pos_s2 && (numk_s2 <= -normk_s2)) begin
				side_s3.mode <= YAW_NEG;
				uy_s3 <= ArgW'(qy_s2);
				ux_s3 <= ArgW'(qx_s2);
			end else if (norm_pos_s2 && (numk_s2 >= normk_s2)) begin
				side_s3.mode <= YAW_POS;
				uy_s3 <= ArgW'(qy_s2);
				ux_s3 <= ArgW'(qx_s2);
			end else begin
				side_s3.mode <= YAW_DIRECT;
				uy_s3 <= ArgW'(yy_s2);
				ux_s3 <= ArgW'(yx_s2);
			end
		end
	end

	// yaw and bearing atan2 run side by side
	logic signed [AngW-1:0] yz, bz;

	rtp_atan2 #(.Iterations(N)) u_yaw_atan (
		.clk (clk),
		.en  (adv[N+6:3]),
		.y   (uy_s3),
		.x   (ux_s3),
		.z   (yz)
	);

	rtp_atan2 #(.Iterations(N)) u_brg_atan (
		.clk (clk),
		.en  (adv[N+6:3]),
		.y   (ArgW'(side_s3.dy)),
		.x   (ArgW'(side_s3.dx)),
		.z   (bz)
	);

	side_t ud_sk [N+4];

	for (genvar j = 0; j < N + 4; j++) begin : g_ud
		always_ff @(posedge clk) begin
			if (adv[3+j]) begin
				ud_sk[j] <= (j == 0) ? side_s3 : ud_sk[(j == 0) ? 0 : j - 1];
			end
		end
	end

	// w1: yaw
	logic signed [33:0] yaw, yaw_w1;
	logic signed [34:0] rp_w1;
	logic signed [AngW-1:0] bz_w1;
	side_t side_w1;

	always_comb begin
		unique case (ud_sk[N+3].mode)
			YAW_NEG: yaw = -(34'(yz) <<< 1);
			YAW_POS: yaw = 34'(yz) <<< 1;
			default: yaw = 34'(yz);
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[KW1]) begin
			yaw_w1 <= yaw;
			rp_w1 <= 35'(yaw) + 35'(PI28);
			bz_w1 <= bz;
			side_w1 <= ud_sk[N+3];
		end
	end

	// w2: wrap yaw into [-pi, pi), raw bearing rounded to Q3.13
	logic signed [34:0] rw;
	logic signed [AngW-1:0] r_w2;
	logic signed [19:0] bd_w2;
	side_t side_w2;

	always_comb begin
		if (rp_w1 < -TwoPiW) begin
			rw = rp_w1 + FourPiW;
		end else if (rp_w1 < 0) begin
			rw = rp_w1 + TwoPiW;
		end else if (rp_w1 >= FourPiW) begin
			rw = rp_w1 - FourPiW;
		end else if (rp_w1 >= TwoPiW) begin
			rw = rp_w1 - TwoPiW;
		end else begin
			rw = rp_w1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[KW2]) begin
			r_w2 <= AngW'(rw - 35'(PI28));
			bd_w2 <= 20'((35'(bz_w1) - 35'(yaw_w1) + 35'sd16384) >>> 15);
			side_w2 <= side_w1;
		end
	end

	// w3: fold to the right half plane, wrap bearing; feeds rotation index 0
	logic signed [32:0] rx_sk [N+1];
	logic signed [32:0] ry_sk [N+1];
	logic signed [AngW-1:0] ra_sk [N+1];
	rside_t rs_sk [N+1];
	logic signed [20:0] bp, bq;

	always_comb begin
		bp = 21'(bd_w2) + PI13;
		if (bp < -TWO_PI13) begin
			bq = bp + (TWO_PI13 <<< 1);
		end else if (bp < 0) begin
			bq = bp + TWO_PI13;
		end else if (bp >= (TWO_PI13 <<< 1)) begin
			bq = bp - (TWO_PI13 <<< 1);
		end else if (bp >= TWO_PI13) begin
			bq = bp - TWO_PI13;
		end else begin
			bq = bp;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[KW3]) begin
			rx_sk[0] <= INV_GAIN30;
			ry_sk[0] <= '0;
			if (r_w2 > HALF_PI28) begin
				ra_sk[0] <= r_w2 - PI28;
				rs_sk[0].flip <= 1'b1;
			end else if (r_w2 < -HALF_PI28) begin
				ra_sk[0] <= r_w2 + PI28;
				rs_sk[0].flip <= 1'b1;
			end else begin
				ra_sk[0] <= r_w2;
				rs_sk[0].flip <= 1'b0;
			end
			rs_sk[0].dx <= side_w2.dx;
			rs_sk[0].dy <= side_w2.dy;
			rs_sk[0].up <= side_w2.up;
			rs_sk[0].b <= 16'(bq - PI13);
		end
	end

	// rotation cordic for sin and cos, Q.30
	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (adv[KRot+i]) begin
				if (ra_sk[i] >= 0) begin
					rx_sk[i+1] <= rx_sk[i] - (ry_sk[i] >>> i);
					ry_sk[i+1] <= ry_sk[i] + (rx_sk[i] >>> i);
					ra_sk[i+1] <= ra_sk[i] - atan_entry(i);
				end else begin
					rx_sk[i+1] <= rx_sk[i] + (ry_sk[i] >>> i);
					ry_sk[i+1] <= ry_sk[i] - (rx_sk[i] >>> i);
					ra_sk[i+1] <= ra_sk[i] + atan_entry(i);
				end
				rs_sk[i+1] <= rs_sk[i];
			end
		end
	end

	// f1: undo the fold, round Q.30 to Q.28
	logic signed [32:0] cfx, cfy;
	logic signed [31:0] c_f1, s_f1;
	rside_t rs_f1;

	always_comb begin
		cfx = rs_sk[N].flip ? -rx_sk[N] : rx_sk[N];
		cfy = rs_sk[N].flip ? -ry_sk[N] : ry_sk[N];
	end

	always_ff @(posedge clk) begin
		if (adv[KF1]) begin
			c_f1 <= 32'((cfx + 33'sd2) >>> 2);
			s_f1 <= 32'((cfy + 33'sd2) >>> 2);
			rs_f1 <= rs_sk[N];
		end
	end

	// m1: rotation products
	logic signed [64:0] pcdx_m1, psdy_m1, pcdy_m1, psdx_m1;
	rside_t rs_m1;

	always_ff @(posedge clk) begin
		if (adv[KM1]) begin
			pcdx_m1 <= 65'(c_f1) * 65'(rs_f1.dx);
			psdy_m1 <= 65'(s_f1) * 65'(rs_f1.dy);
			pcdy_m1 <= 65'(c_f1) * 65'(rs_f1.dy);
			psdx_m1 <= 65'(s_f1) * 65'(rs_f1.dx);
			rs_m1 <= rs_f1;
		end
	end

	// m2: round to Q16.16 and saturate
	logic signed [65:0] fsum, lsum;
	rel_t rel_m2;

	always_comb begin
		fsum = (66'(pcdx_m1) + 66'(psdy_m1) + 66'sd134217728) >>> 28;
		lsum = (66'(pcdy_m1) - 66'(psdx_m1) + 66'sd134217728) >>> 28;
	end

	always_ff @(posedge clk) begin
		if (adv[KM2]) begin
			if (fsum > SatMax) begin
				rel_m2.rel_forward <= 32'sh7fffffff;
			end else if (fsum < SatMin) begin
				rel_m2.rel_forward <= 32'sh80000000;
			end else begin
				rel_m2.rel_forward <= fsum[31:0];
			end
			if (lsum > SatMax) begin
				rel_m2.rel_left <= 32'sh7fffffff;
			end else if (lsum < SatMin) begin
				rel_m2.rel_left <= 32'sh80000000;
			end else begin
				rel_m2.rel_left <= lsum[31:0];
			end
			rel_m2.rel_up <= rs_m1.up;
			rel_m2.bearing <= rs_m1.b;
		end
	end

	assign rel = rel_m2;

	// input backs up only with every stage full and the result held
	`RTP_ASSERT_IMP(a_stall_full, pose_stall, (&v_q) && rel_stall)
	// with the output free, every stage moves
	`RTP_ASSERT_IMP(a_free_flow, !rel_stall, &adv)
	// an accepted item occupies the first stage
	`RTP_ASSERT_NXT(a_enter, pose_valid && !pose_stall, v_q[0])

endmodule

// ----- tb/relative_target_pose_tb.sv -----
`timescale 1ns / 1ps

module relative_target_pose_tb import rtp_pkg::*; ();

	localparam int STEPS      = 16;
	localparam int N_RANDOM   = 800;
	localparam int QUIET_TAIL = 100;
	localparam int LONG_HOLD  = 300;
	localparam int DRAIN      = 60;
	localparam int STALL_MAX  = 5000;

	localparam longint PI_Q28      = 64'sd843314857;
	localparam longint TWO_PI_Q28  = 64'sd1686629714;
	localparam longint HALF_PI_Q28 = 64'sd421657428;
	localparam longint ROT_START   = 64'sd652032874;
	localparam longint PI_Q13      = 64'sd25736;
	localparam longint TWO_PI_Q13  = 64'sd51472;

	localparam longint ATAN_Q28 [24] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963, 2097109,
		1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32
	};

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  pose_valid = 1'b0;
	logic  pose_stall;
	pose_t pose = '0;
	logic  rel_valid;
	logic  rel_stall = 1'b0;
	rel_t  rel;

	relative_target_pose i_dut (
		.clk(clk), .arst_n(arst_n),
		.pose_valid(pose_valid), .pose_stall(pose_stall), .pose(pose),
		.rel_valid(rel_valid), .rel_stall(rel_stall), .rel(rel)
	);

	always #2 clk = ~clk;

	rel_t   pending_rel [$];
	pose_t  stim_q [$];
	bit     typed_q [$];
	rel_t   typed_rel_q [$];
	int     mismatches = 0;
	int     n_sent = 0;
	int     n_checked = 0;
	bit     quiet = 1'b0;
	bit     long_hold_req = 1'b0;

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	// vectoring cordic, Q.28 result
	function automatic longint vec_angle(longint y, longint x);
		longint base, z, nx, ny, lim;
		base = 0;
		z = 0;
		lim = 64'sd1 <<< 40;
		if (x == 0 && y == 0)
			return 0;
		while (absl(x) < lim && absl(y) < lim) begin
			x = x * 2;
			y = y * 2;
		end
		if (x < 0) begin
			base = (y >= 0) ? PI_Q28 : -PI_Q28;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_Q28[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_Q28[i];
			end
			x = nx;
			y = ny;
		end
		return base + z;
	endfunction

	function automatic void rot_sincos(longint a, output longint c, output longint s);
		longint r, x, y, nx, ny;
		bit flip;
		r = (a + PI_Q28) % TWO_PI_Q28;
		x = ROT_START;
		y = 0;
		flip = 1'b0;
		if (r < 0) r += TWO_PI_Q28;
		r -= PI_Q28;
		if (r > HALF_PI_Q28) begin
			r -= PI_Q28; flip = 1'b1;
		end else if (r < -HALF_PI_Q28) begin
			r += PI_Q28; flip = 1'b1;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			if (r >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i); r -= ATAN_Q28[i];
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i); r += ATAN_Q28[i];
			end
			x = nx;
			y = ny;
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = (x + 2) >>> 2;
		s = (y + 2) >>> 2;
	endfunction

	function automatic longint heading_of(longint qx, longint qy, longint qz, longint qw);
		longint sx, sy, sz, sw, norm, num;
		sx = qx * qx; sy = qy * qy; sz = qz * qz; sw = qw * qw;
		norm = sx + sy + sz + sw;
		num = 2 * (qw * qy - qx * qz);
		if (norm > 0) begin
			if (num * 100000 <= -99999 * norm) return -2 * vec_angle(qy, qx);
			if (num * 100000 >= 99999 * norm) return 2 * vec_angle(qy, qx);
		end
		return vec_angle(2 * (qx * qy + qw * qz), sw + sx - sy - sz);
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic rel_t predict_rel(pose_t p);
		rel_t r;
		longint dx, dy, yaw, c, s, b;
		dx = longint'(p.target_x) - longint'(p.vehicle_x);
		dy = longint'(p.target_y) - longint'(p.vehicle_y);
		yaw = heading_of(longint'(p.quat_i), longint'(p.quat_j),
			longint'(p.quat_k), longint'(p.quat_real));
		rot_sincos(yaw, c, s);
		r.rel_forward = clip32((c * dx + s * dy + (64'sd1 <<< 27)) >>> 28);
		r.rel_left = clip32((c * dy - s * dx + (64'sd1 <<< 27)) >>> 28);
		r.rel_up = clip32(longint'(p.target_z) - longint'(p.vehicle_z));
		b = (vec_angle(dy, dx) - yaw + (64'sd1 <<< 14)) >>> 15;
		b = (b + PI_Q13) % TWO_PI_Q13;
		if (b < 0) b += TWO_PI_Q13;
		b -= PI_Q13;
		r.bearing = b[15:0];
		return r;
	endfunction

	function automatic pose_t mk_pose(int tx, int ty, int tz, int vx, int vy, int vz,
		shortint qi, shortint qj, shortint qk, shortint qw);
		pose_t p;
		p.target_x = tx; p.target_y = ty; p.target_z = tz;
		p.vehicle_x = vx; p.vehicle_y = vy; p.vehicle_z = vz;
		p.quat_i = qi; p.quat_j = qj; p.quat_k = qk; p.quat_real = qw;
		return p;
	endfunction

	function automatic logic signed [31:0] rand_pos();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
				: 32'sh80000000 + $urandom_range(0, 3);
			1, 2: return $signed($urandom_range(0, 32'h1fffff)) - 32'sd1048576;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_row(pose_t p, bit typed, rel_t r);
		stim_q.push_back(p);
		typed_q.push_back(typed);
		typed_rel_q.push_back(r);
	endtask

	task automatic add_random();
		pose_t p;
		shortint a, b;
		p.target_x = rand_pos(); p.target_y = rand_pos(); p.target_z = rand_pos();
		p.vehicle_x = rand_pos(); p.vehicle_y = rand_pos(); p.vehicle_z = rand_pos();
		a = 16'($urandom);
		b = 16'($urandom);
		case ($urandom_range(0, 7))
			0: begin // gimbal lock, sign random
				p.quat_real = a; p.quat_j = $urandom_range(0, 1) ? a : -a;
				p.quat_i = b; p.quat_k = (p.quat_j == a) ? -b : b;
				if ($urandom_range(0, 1))
					p.quat_j = 16'(p.quat_j + $signed($urandom_range(0, 2)) - 1);
			end
			1: {p.quat_i, p.quat_j, p.quat_k, p.quat_real} = '0;
			2: begin // pure yaw
				p.quat_i = '0; p.quat_j = '0;
				p.quat_k = 16'($signed($urandom_range(0, 32768)) - 16384);
				p.quat_real = 16'($signed($urandom_range(0, 32768)) - 16384);
			end
			default: {p.quat_i, p.quat_j, p.quat_k, p.quat_real} = {$urandom, $urandom};
		endcase
		add_row(p, 1'b0, '0);
	endtask

	// receiver side stall pattern
	int stall_left = 0;
	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			rel_stall <= 1'b0;
			stall_left = 0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			stall_left = LONG_HOLD;
			rel_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
		end else begin
			stall_left = $urandom_range(1, 10);
			rel_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// result check
	always @(posedge clk) begin
		rel_t want;
		if (arst_n && rel_valid && !rel_stall) begin
			if (pending_rel.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %p", rel);
			end else begin
				want = pending_rel.pop_front();
				n_checked++;
				if (rel.rel_forward !== want.rel_forward || rel.rel_left !== want.rel_left ||
					rel.rel_up !== want.rel_up || rel.bearing !== want.bearing) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected fwd %0d left %0d up %0d bearing %0d,",
							n_checked, want.rel_forward, want.rel_left, want.rel_up,
							want.bearing, " got fwd %0d left %0d up %0d bearing %0d",
							rel.rel_forward, rel.rel_left, rel.rel_up, rel.bearing);
				end
			end
		end
	end

	// watchdog on cycles with no transfer
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((pose_valid && !pose_stall) || (rel_valid && !rel_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_MAX) begin
			$display("relative_target_pose: mismatch");
			$finish;
		end
	end

	initial begin
		rel_t zero_rel, up_hi, up_lo;
		int gap;
		zero_rel = '0;
		up_hi = '0; up_hi.rel_up = 32'sh7fffffff;
		up_lo = '0; up_lo.rel_up = 32'sh80000000;

		// directed rows
		add_row(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_rel);
		add_row(mk_pose(5, 7, 32'sh7fffffff, 5, 7, 32'sh80000000, 0, 0, 0, 0), 1'b1, up_hi);
		add_row(mk_pose(-9, 3, 32'sh80000000, -9, 3, 32'sh7fffffff, 0, 0, 0, 0), 1'b1, up_lo);
		add_row(mk_pose(32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 0, 0, 0, 16384), 1'b0, '0);
		add_row(mk_pose(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 0, 16384), 1'b0, '0);
		add_row(mk_pose(0, 32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 0, 16384, 0), 1'b0, '0);
		add_row(mk_pose(0, 32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, 0, 11585, 11585), 1'b0, '0);
		// bearing rounding onto pi wraps to minus pi
		add_row(mk_pose(-65536, 0, 0, 0, 0, 0, 0, 0, 0, 16384), 1'b0, '0);
		add_row(mk_pose(-65536, 1, 0, 0, 0, 0, 0, 0, 0, 16384), 1'b0, '0);
		// target on vehicle, nonzero yaw
		add_row(mk_pose(100, 200, 300, 100, 200, 300, 0, 0, 9000, 12000), 1'b0, '0);
		// gimbal lock both signs
		add_row(mk_pose(65536, 131072, 0, 0, 0, 0, 3000, 8000, -3000, 8000), 1'b0, '0);
		add_row(mk_pose(65536, 131072, 0, 0, 0, 0, 3000, -8000, 3000, 8000), 1'b0, '0);
		// unnormalized and extreme quaternions
		add_row(mk_pose(12345, -6789, 1, 2, 3, 4, 3, 0, 0, 1), 1'b0, '0);
		add_row(mk_pose(1 << 20, 1 << 19, 0, 0, 0, 0, -32768, -32768, -32768, -32768), 1'b0, '0);
		add_row(mk_pose(1 << 20, 1 << 19, 0, 0, 0, 0, 32767, 32767, 32767, 32767), 1'b0, '0);
		add_row(mk_pose(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 7000, -7000), 1'b0, '0);
		for (int i = 0; i < N_RANDOM; i++)
			add_random();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_q[idx]) begin
			if (idx == stim_q.size() - QUIET_TAIL)
				quiet = 1'b1;
			if (idx == 300)
				long_hold_req = 1'b1;
			if (idx == 500) begin
				// sender holds back until the pipeline has drained
				pose_valid <= 1'b0;
				@(posedge clk);
				while (pending_rel.size() != 0) @(posedge clk);
			end else if (!quiet && idx > 20 && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 10);
				pose_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pose <= stim_q[idx];
			pose_valid <= 1'b1;
			@(posedge clk);
			while (pose_stall) @(posedge clk);
			pending_rel.push_back(typed_q[idx] ? typed_rel_q[idx] : predict_rel(stim_q[idx]));
			n_sent++;
		end
		pose_valid <= 1'b0;

		while (pending_rel.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d pose transfers (directed extremes, gimbal lock, zero quaternion)",
			n_sent);
		$display("checked %0d results under random stalls, one long hold and one drain",
			n_checked);
		if (mismatches == 0 && pending_rel.size() == 0) begin
			$display("relative_target_pose: match");
		end else begin
			$display("relative_target_pose: mismatch");
		end
		$finish;
	end

endmodule
